### hw/rtl/grid_maze_depth_first_solver_top_macros.svh
// assertion macros for the maze solver
`ifndef GRID_MAZE_DEPTH_FIRST_SOLVER_TOP_MACROS_SVH
`define GRID_MAZE_DEPTH_FIRST_SOLVER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// antecedent and consequent in the same cycle
`define GMDS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gmds: check failed");

// consequent in the cycle after the antecedent
`define GMDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gmds: check failed");

`else

`define GMDS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define GMDS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### hw/rtl/gmds_pkg.sv
package gmds_pkg;

    // operation codes
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_SOLVE = 2'd2;

    // result status codes
    localparam logic [1:0] ST_DONE       = 2'd0;
    localparam logic [1:0] ST_EXITED     = 2'd1;
    localparam logic [1:0] ST_IMPOSSIBLE = 2'd2;
    localparam logic [1:0] ST_OVERFLOW   = 2'd3;

    // configuration register indexes
    localparam logic CFG_ROW_COUNT = 1'b0;
    localparam logic CFG_COL_COUNT = 1'b1;

    localparam int CFG_W = 6;
    localparam logic [CFG_W-1:0] CFG_COUNT_RESET = 6'd32;

    // cell characters
    localparam logic [7:0] CH_EXIT    = 8'h58;
    localparam logic [7:0] CH_ENTRY   = 8'h4E;
    localparam logic [7:0] CH_WALL    = 8'h2B;
    localparam logic [7:0] CH_PASSAGE = 8'h20;
    localparam logic [7:0] CH_VISITED = 8'h2E;

    typedef struct packed {
        logic [1:0] operation;
        logic [4:0] row;
        logic [4:0] col;
        logic [7:0] cell_value;
    } item_t;

    typedef struct packed {
        logic [7:0] read_value;
        logic [1:0] status;
    } result_t;

    // memory port control
    typedef struct packed {
        logic en;
        logic we;
    } mem_ctl_t;

endpackage

### hw/rtl/gmds_ram.sv
module gmds_ram #(
    parameter int DEPTH = 1024,
    parameter int DATA_W = 8,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                clk,
    input  gmds_pkg::mem_ctl_t  ctl,
    input  logic [AW-1:0]       addr,
    input  logic [DATA_W-1:0]   wdata,
    output logic [DATA_W-1:0]   rdata
);

    import gmds_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // single port, registered read
    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            if (ctl.we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/gmds_ctrl.sv
module gmds_ctrl #(
    parameter int MAX_ROWS = 32,
    parameter int MAX_COLS = 32,
    parameter int STACK_DEPTH = 4096,
    localparam int RW = $clog2(MAX_ROWS),
    localparam int CW = $clog2(MAX_COLS),
    localparam int ERW = $clog2(MAX_ROWS + 1),
    localparam int ECW = $clog2(MAX_COLS + 1),
    localparam int AW = $clog2(MAX_ROWS * MAX_COLS),
    localparam int SW = $clog2(STACK_DEPTH),
    localparam int EW = RW + CW
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  gmds_pkg::item_t     item,
    input  logic [ERW-1:0]      eff_rows,
    input  logic [ECW-1:0]      eff_cols,
    output logic                result_valid,
    output gmds_pkg::result_t   result,
    output gmds_pkg::mem_ctl_t  grid_ctl,
    output logic [AW-1:0]       grid_addr,
    output logic [7:0]          grid_wdata,
    input  logic [7:0]          grid_rdata,
    output gmds_pkg::mem_ctl_t  stack_ctl,
    output logic [SW-1:0]       stack_addr,
    output logic [EW-1:0]       stack_wdata,
    input  logic [EW-1:0]       stack_rdata
);

    import gmds_pkg::*;

    localparam int TW = $clog2(STACK_DEPTH + 1);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_SCAN      = 3'd1;
    localparam logic [2:0] S_SCAN_LAST = 3'd2;
    localparam logic [2:0] S_CHECK     = 3'd3;
    localparam logic [2:0] S_NB_ISSUE  = 3'd4;
    localparam logic [2:0] S_NB_EVAL   = 3'd5;
    localparam logic [2:0] S_POP       = 3'd6;
    localparam logic [2:0] S_POP_WAIT  = 3'd7;

    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    // control state
    logic [2:0]    state_reg, state_next;
    logic [TW-1:0] top_reg, top_next;
    logic          pend_valid_reg, pend_valid_next;
    logic          res_valid_reg, res_valid_next;
    logic          is_read_reg, is_read_next;

    // payload state
    logic [1:0]    status_reg, status_next;
    logic [RW-1:0] scan_r_reg, scan_r_next;
    logic [CW-1:0] scan_c_reg, scan_c_next;
    logic [RW-1:0] pend_r_reg, pend_r_next;
    logic [CW-1:0] pend_c_reg, pend_c_next;
    logic          found_n_reg, found_n_next;
    logic          found_x_reg, found_x_next;
    logic [RW-1:0] entry_r_reg, entry_r_next;
    logic [CW-1:0] entry_c_reg, entry_c_next;
    logic [RW-1:0] goal_r_reg, goal_r_next;
    logic [CW-1:0] goal_c_reg, goal_c_next;
    logic [RW-1:0] cur_r_reg, cur_r_next;
    logic [CW-1:0] cur_c_reg, cur_c_next;
    logic [RW-1:0] nb_r_reg, nb_r_next;
    logic [CW-1:0] nb_c_reg, nb_c_next;
    logic [1:0]    nb_sel_reg, nb_sel_next;

    // combinational helpers
    logic          accept;
    logic          in_inside;
    logic [RW-1:0] in_r;
    logic [CW-1:0] in_c;
    logic          ev_found_n, ev_found_x;
    logic [RW-1:0] ev_entry_r, ev_goal_r;
    logic [CW-1:0] ev_entry_c, ev_goal_c;
    logic          nb_ok;
    logic [RW-1:0] nb_r;
    logic [CW-1:0] nb_c;
    logic          at_goal;
    logic          scan_row_end, scan_col_end;
    logic          cell_open;
    logic [TW-1:0] top_dec;

    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r,
                                                 input logic [CW-1:0] c);
        cell_addr = AW'(r) * AW'(MAX_COLS) + AW'(c);
    endfunction

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign in_inside = (32'(item.row) < MAX_ROWS) && (32'(item.col) < MAX_COLS);
    assign in_r      = RW'(item.row);
    assign in_c      = CW'(item.col);
    assign at_goal   = (cur_r_reg == goal_r_reg) && (cur_c_reg == goal_c_reg);
    assign scan_row_end = (ERW'(scan_r_reg) + ERW'(1)) == eff_rows;
    assign scan_col_end = (ECW'(scan_c_reg) + ECW'(1)) == eff_cols;
    assign cell_open = (grid_rdata == CH_PASSAGE) || (grid_rdata == CH_EXIT);
    assign top_dec   = top_reg - TW'(1);

    // entry and exit search on the cell returned by the scan read
    always_comb
    begin
        ev_found_n = found_n_reg;
        ev_found_x = found_x_reg;
        ev_entry_r = entry_r_reg;
        ev_entry_c = entry_c_reg;
        ev_goal_r  = goal_r_reg;
        ev_goal_c  = goal_c_reg;
        if (pend_valid_reg && ((state_reg == S_SCAN) || (state_reg == S_SCAN_LAST)))
        begin
            if (!found_n_reg && (grid_rdata == CH_ENTRY))
            begin
                ev_found_n = 1'b1;
                ev_entry_r = pend_r_reg;
                ev_entry_c = pend_c_reg;
            end
            if (!found_x_reg && (grid_rdata == CH_EXIT))
            begin
                ev_found_x = 1'b1;
                ev_goal_r  = pend_r_reg;
                ev_goal_c  = pend_c_reg;
            end
        end
    end

    // neighbor selection for the current cell
    always_comb
    begin
        nb_ok = 1'b0;
        nb_r  = cur_r_reg;
        nb_c  = cur_c_reg;
        unique case (nb_sel_reg)
            DIR_UP:
            begin
                nb_ok = (cur_r_reg != '0);
                nb_r  = cur_r_reg - RW'(1);
            end
            DIR_DOWN:
            begin
                nb_ok = (ERW'(cur_r_reg) + ERW'(1)) < eff_rows;
                nb_r  = cur_r_reg + RW'(1);
            end
            DIR_LEFT:
            begin
                nb_ok = (cur_c_reg != '0);
                nb_c  = cur_c_reg - CW'(1);
            end
            DIR_RIGHT:
            begin
                nb_ok = (ECW'(cur_c_reg) + ECW'(1)) < eff_cols;
                nb_c  = cur_c_reg + CW'(1);
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        top_next        = top_reg;
        pend_valid_next = 1'b0;
        res_valid_next  = 1'b0;
        is_read_next    = 1'b0;
        status_next     = status_reg;
        scan_r_next     = scan_r_reg;
        scan_c_next     = scan_c_reg;
        pend_r_next     = pend_r_reg;
        pend_c_next     = pend_c_reg;
        found_n_next    = found_n_reg;
        found_x_next    = found_x_reg;
        entry_r_next    = entry_r_reg;
        entry_c_next    = entry_c_reg;
        goal_r_next     = goal_r_reg;
        goal_c_next     = goal_c_reg;
        cur_r_next      = cur_r_reg;
        cur_c_next      = cur_c_reg;
        nb_r_next       = nb_r_reg;
        nb_c_next       = nb_c_reg;
        nb_sel_next     = nb_sel_reg;
        grid_ctl        = '0;
        grid_addr       = cell_addr(cur_r_reg, cur_c_reg);
        grid_wdata      = CH_VISITED;
        stack_ctl       = '0;
        stack_addr      = top_reg[SW-1:0];
        stack_wdata     = {nb_r_reg, nb_c_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    grid_addr  = cell_addr(in_r, in_c);
                    grid_wdata = item.cell_value;
                    if (item.operation == OP_SOLVE)
                    begin
                        top_next     = '0;
                        found_n_next = 1'b0;
                        found_x_next = 1'b0;
                        entry_r_next = '0;
                        entry_c_next = '0;
                        goal_r_next  = '0;
                        goal_c_next  = '0;
                        cur_r_next   = '0;
                        cur_c_next   = '0;
                        scan_r_next  = '0;
                        scan_c_next  = '0;
                        if ((eff_rows == '0) || (eff_cols == '0))
                        begin
                            state_next = S_CHECK;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    else
                    begin
                        // access answers in the next cycle
                        res_valid_next = 1'b1;
                        status_next    = ST_DONE;
                        if (in_inside && (item.operation == OP_WRITE))
                        begin
                            grid_ctl = '{en: 1'b1, we: 1'b1};
                        end
                        if (in_inside && (item.operation == OP_READ))
                        begin
                            grid_ctl     = '{en: 1'b1, we: 1'b0};
                            is_read_next = 1'b1;
                        end
                    end
                end
            end

            S_SCAN:
            begin
                found_n_next    = ev_found_n;
                found_x_next    = ev_found_x;
                entry_r_next    = ev_entry_r;
                entry_c_next    = ev_entry_c;
                goal_r_next     = ev_goal_r;
                goal_c_next     = ev_goal_c;
                grid_ctl        = '{en: 1'b1, we: 1'b0};
                grid_addr       = cell_addr(scan_r_reg, scan_c_reg);
                pend_valid_next = 1'b1;
                pend_r_next     = scan_r_reg;
                pend_c_next     = scan_c_reg;
                if (scan_col_end)
                begin
                    scan_c_next = '0;
                    if (scan_row_end)
                    begin
                        state_next = S_SCAN_LAST;
                    end
                    else
                    begin
                        scan_r_next = scan_r_reg + RW'(1);
                    end
                end
                else
                begin
                    scan_c_next = scan_c_reg + CW'(1);
                end
            end

            S_SCAN_LAST:
            begin
                found_n_next = ev_found_n;
                found_x_next = ev_found_x;
                entry_r_next = ev_entry_r;
                entry_c_next = ev_entry_c;
                goal_r_next  = ev_goal_r;
                goal_c_next  = ev_goal_c;
                cur_r_next   = ev_entry_r;
                cur_c_next   = ev_entry_c;
                state_next   = S_CHECK;
            end

            S_CHECK:
            begin
                if (at_goal)
                begin
                    res_valid_next = 1'b1;
                    status_next    = ST_EXITED;
                    state_next     = S_IDLE;
                end
                else
                begin
                    // mark the current cell visited
                    grid_ctl    = '{en: 1'b1, we: 1'b1};
                    nb_sel_next = DIR_UP;
                    state_next  = S_NB_ISSUE;
                end
            end

            S_NB_ISSUE:
            begin
                grid_addr = cell_addr(nb_r, nb_c);
                if (nb_ok)
                begin
                    grid_ctl   = '{en: 1'b1, we: 1'b0};
                    nb_r_next  = nb_r;
                    nb_c_next  = nb_c;
                    state_next = S_NB_EVAL;
                end
                else if (nb_sel_reg == DIR_RIGHT)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    nb_sel_next = nb_sel_reg + 2'd1;
                end
            end

            S_NB_EVAL:
            begin
                if (cell_open && (top_reg == TW'(STACK_DEPTH)))
                begin
                    res_valid_next = 1'b1;
                    status_next    = ST_OVERFLOW;
                    state_next     = S_IDLE;
                end
                else
                begin
                    if (cell_open)
                    begin
                        stack_ctl = '{en: 1'b1, we: 1'b1};
                        top_next  = top_reg + TW'(1);
                    end
                    if (nb_sel_reg == DIR_RIGHT)
                    begin
                        state_next = S_POP;
                    end
                    else
                    begin
                        nb_sel_next = nb_sel_reg + 2'd1;
                        state_next  = S_NB_ISSUE;
                    end
                end
            end

            S_POP:
            begin
                stack_addr = top_dec[SW-1:0];
                if (top_reg == '0)
                begin
                    res_valid_next = 1'b1;
                    status_next    = ST_IMPOSSIBLE;
                    state_next     = S_IDLE;
                end
                else
                begin
                    stack_ctl  = '{en: 1'b1, we: 1'b0};
                    top_next   = top_dec;
                    state_next = S_POP_WAIT;
                end
            end

            S_POP_WAIT:
            begin
                cur_r_next = stack_rdata[EW-1:CW];
                cur_c_next = stack_rdata[CW-1:0];
                state_next = S_CHECK;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            top_reg        <= '0;
            pend_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
            is_read_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            top_reg        <= top_next;
            pend_valid_reg <= pend_valid_next;
            res_valid_reg  <= res_valid_next;
            is_read_reg    <= is_read_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        scan_r_reg  <= scan_r_next;
        scan_c_reg  <= scan_c_next;
        pend_r_reg  <= pend_r_next;
        pend_c_reg  <= pend_c_next;
        found_n_reg <= found_n_next;
        found_x_reg <= found_x_next;
        entry_r_reg <= entry_r_next;
        entry_c_reg <= entry_c_next;
        goal_r_reg  <= goal_r_next;
        goal_c_reg  <= goal_c_next;
        cur_r_reg   <= cur_r_next;
        cur_c_reg   <= cur_c_next;
        nb_r_reg    <= nb_r_next;
        nb_c_reg    <= nb_c_next;
        nb_sel_reg  <= nb_sel_next;
    end

    // result, read data comes straight from the grid memory output register
    assign result_valid = res_valid_reg;
    always_comb
    begin
        result.read_value = is_read_reg ? grid_rdata : 8'd0;
        result.status     = status_reg;
    end

endmodule

### hw/rtl/grid_maze_depth_first_solver_top.sv
// Depth-first maze solver over a byte grid of MAX_ROWS x MAX_COLS cells. A write or a read
// is taken in any cycle in which busy is low and gives its result, with result_valid high,
// in the cycle right after the transfer, so accesses run one per clock. A solve raises
// busy until its result: it first reads every active cell to find the entry and exit,
// then for each visited cell it marks the cell, reads each neighbor inside the active
// area (neighbors outside it are skipped), pushes the open ones onto the stack, and
// pops the next cell. Each result is shown for a single cycle and must be taken then;
// there is no way to hold it off. Grid contents are undefined after reset until
// written, and reset needs no clearing pass.
`include "grid_maze_depth_first_solver_top_macros.svh"

module grid_maze_depth_first_solver_top #(
    parameter int MAX_ROWS = 32,
    parameter int MAX_COLS = 32,
    parameter int STACK_DEPTH = 4096
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  gmds_pkg::item_t              item,
    output logic                         result_valid,
    output gmds_pkg::result_t            result,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic                         cfg_index,
    input  logic [gmds_pkg::CFG_W-1:0]   cfg_data
);

    import gmds_pkg::*;

    localparam int RW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_COLS);
    localparam int ERW = $clog2(MAX_ROWS + 1);
    localparam int ECW = $clog2(MAX_COLS + 1);
    localparam int AW = $clog2(MAX_ROWS * MAX_COLS);
    localparam int SW = $clog2(STACK_DEPTH);
    localparam int EW = RW + CW;

    logic [CFG_W-1:0] row_count_reg, row_count_next;
    logic [CFG_W-1:0] col_count_reg, col_count_next;
    logic [ERW-1:0]   eff_rows;
    logic [ECW-1:0]   eff_cols;

    mem_ctl_t         grid_ctl;
    logic [AW-1:0]    grid_addr;
    logic [7:0]       grid_wdata;
    logic [7:0]       grid_rdata;
    mem_ctl_t         stack_ctl;
    logic [SW-1:0]    stack_addr;
    logic [EW-1:0]    stack_wdata;
    logic [EW-1:0]    stack_rdata;

    // configuration registers, ready while no solve runs
    assign cfg_ready = !busy;

    always_comb
    begin
        row_count_next = row_count_reg;
        col_count_next = col_count_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ROW_COUNT: row_count_next = cfg_data;
                CFG_COL_COUNT: col_count_next = cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= CFG_COUNT_RESET;
            col_count_reg <= CFG_COUNT_RESET;
        end
        else
        begin
            row_count_reg <= row_count_next;
            col_count_reg <= col_count_next;
        end
    end

    // active area, clipped to the grid size
    assign eff_rows = (32'(row_count_reg) > MAX_ROWS) ? ERW'(MAX_ROWS) : ERW'(row_count_reg);
    assign eff_cols = (32'(col_count_reg) > MAX_COLS) ? ECW'(MAX_COLS) : ECW'(col_count_reg);

    gmds_ctrl #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLS    (MAX_COLS),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .eff_rows     (eff_rows),
        .eff_cols     (eff_cols),
        .result_valid (result_valid),
        .result       (result),
        .grid_ctl     (grid_ctl),
        .grid_addr    (grid_addr),
        .grid_wdata   (grid_wdata),
        .grid_rdata   (grid_rdata),
        .stack_ctl    (stack_ctl),
        .stack_addr   (stack_addr),
        .stack_wdata  (stack_wdata),
        .stack_rdata  (stack_rdata)
    );

    // cell grid
    gmds_ram #(
        .DEPTH  (MAX_ROWS * MAX_COLS),
        .DATA_W (8)
    ) u_grid_ram (
        .clk   (clk),
        .ctl   (grid_ctl),
        .addr  (grid_addr),
        .wdata (grid_wdata),
        .rdata (grid_rdata)
    );

    // cell stack, entries are row and column
    gmds_ram #(
        .DEPTH  (STACK_DEPTH),
        .DATA_W (EW)
    ) u_stack_ram (
        .clk   (clk),
        .ctl   (stack_ctl),
        .addr  (stack_addr),
        .wdata (stack_wdata),
        .rdata (stack_rdata)
    );

    // checks
    `GMDS_ASSERT_NEXT(a_access_answers, clk, rst_n, start && !busy && item.operation != OP_SOLVE, result_valid)
    `GMDS_ASSERT_NEXT(a_solve_holds_off, clk, rst_n, start && !busy && item.operation == OP_SOLVE, busy && !result_valid)
    `GMDS_ASSERT_SAME(a_solve_ends_with_result, clk, rst_n, $fell(busy), result_valid && result.status != ST_DONE)
    `GMDS_ASSERT_SAME(a_solve_reads_nothing, clk, rst_n, result_valid && result.status != ST_DONE, result.read_value == 8'd0)

endmodule
